// ----- rtl/subarray_palindrome_query_unit_defines.svh -----
// Assertion macros shared by the checker of the palindrome range query unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SUBARRAY_PALINDROME_QUERY_UNIT_DEFINES_SVH
`define SUBARRAY_PALINDROME_QUERY_UNIT_DEFINES_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define SPQ_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spq checker: property violated");

// Same, on the block's own clock and reset.
`define SPQ_ASSERT(lbl, prop) `SPQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/spq_pkg.sv -----
// Package of the palindrome range query unit: sizes, control word types and
// the microcode table. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int MAX_ELEMENTS  = 256;
  localparam int DATA_WIDTH    = 16;
  localparam int IDX_W         = 8;
  localparam int VALUE_W       = 16;
  localparam int LEN_W         = 9;
  localparam int ADDR_W        = $clog2(MAX_ELEMENTS);
  localparam int STEP_W        = 3;

  localparam logic [LEN_W-1:0] SEQ_LEN_RESET = LEN_W'(256);
  localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_ELEMENTS);

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram step addresses
  localparam step_t STEP_IDLE      = 3'd0;
  localparam step_t STEP_LOAD      = 3'd1;
  localparam step_t STEP_RANGE     = 3'd2;
  localparam step_t STEP_ISSUE     = 3'd3;
  localparam step_t STEP_COMPARE   = 3'd4;
  localparam step_t STEP_REPLY     = 3'd5;
  localparam step_t STEP_REPLY_ERR = 3'd6;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_NO_START  = 3'd1,
    COND_IS_LOAD   = 3'd2,
    COND_RANGE_BAD = 3'd3,
    COND_PTR_MET   = 3'd4,
    COND_PAIR_STOP = 3'd5
  } cond_e;

  typedef enum logic {
    ELSE_NEXT = 1'b0,
    ELSE_STAY = 1'b1
  } else_e;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_MATCH = 2'd1,
    RES_ERR   = 2'd2
  } result_e;

  typedef struct packed {
    logic    take_item;
    logic    wr_load;
    logic    rd_issue;
    logic    ptr_adv;
    logic    set_match;
    logic    latch_match;
    result_e res;
    cond_e   cond;
    else_e   els;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic is_load;
    logic range_bad;
    logic ptr_met;
    logic pair_stop;
  } flags_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t cw;
    cw = '{take_item: 1'b0, wr_load: 1'b0, rd_issue: 1'b0, ptr_adv: 1'b0,
           set_match: 1'b0, latch_match: 1'b0, res: RES_NONE,
           cond: COND_ALWAYS, els: ELSE_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        cw.take_item = 1'b1;
        cw.cond      = COND_NO_START;
        cw.target    = STEP_IDLE;
      end
      STEP_LOAD: begin
        cw.wr_load = 1'b1;
        cw.cond    = COND_IS_LOAD;
        cw.target  = STEP_IDLE;
      end
      STEP_RANGE: begin
        cw.cond   = COND_RANGE_BAD;
        cw.target = STEP_REPLY_ERR;
      end
      STEP_ISSUE: begin
        cw.rd_issue  = 1'b1;
        cw.set_match = 1'b1;
        cw.cond      = COND_PTR_MET;
        cw.target    = STEP_REPLY;
      end
      STEP_COMPARE: begin
        cw.rd_issue    = 1'b1;
        cw.ptr_adv     = 1'b1;
        cw.latch_match = 1'b1;
        cw.cond        = COND_PAIR_STOP;
        cw.els         = ELSE_STAY;
        cw.target      = STEP_REPLY;
      end
      STEP_REPLY: begin
        cw.res = RES_MATCH;
      end
      STEP_REPLY_ERR: begin
        cw.res = RES_ERR;
      end
      default: begin
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/subarray_palindrome_query_unit.sv -----
// Palindrome range query unit: top level joining the microcode sequencer
// and the datapath. Depends on spq_pkg, spq_seq and spq_dpath.
//
// Usage: present an item with start_i while busy_o is low; it is taken at
// that clock edge. A load (opcode 0) writes value_i at first_index_i and
// gives no result; busy_o stays high through the load step. A query
// (opcode 1) checks first_index_i..last_index_i against seq_length and then
// compares mirrored pairs from the outside in, one pair per cycle through
// the two read ports of the element store. A bad range holds busy_o in the
// load, range and error-reply steps, a good range in the load, range, issue,
// compare (up to 128 pairs, fewer on a mismatch) and reply steps. The result
// shows for exactly one cycle on result_valid_o, the first cycle in which
// busy_o is low again; it cannot be held off, so the receiver must take it
// then. A new item may be started in the cycle the result is shown. Write
// seq_length through cfg_we_i/cfg_wdata_i only while the unit is idle.
`default_nettype none

module subarray_palindrome_query_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        opcode_i,
  input  wire logic [spq_pkg::IDX_W-1:0]   first_index_i,
  input  wire logic [spq_pkg::IDX_W-1:0]   last_index_i,
  input  wire logic [spq_pkg::VALUE_W-1:0] value_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [spq_pkg::LEN_W-1:0]   cfg_wdata_i,
  output logic                             result_valid_o,
  output logic                             is_palindrome_o,
  output logic                             range_error_o
);
  import spq_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  spq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  spq_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .start_i         (start_i),
    .opcode_i        (opcode_i),
    .first_index_i   (first_index_i),
    .last_index_i    (last_index_i),
    .value_i         (value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .flags_o         (flags),
    .result_valid_o  (result_valid_o),
    .is_palindrome_o (is_palindrome_o),
    .range_error_o   (range_error_o)
  );

endmodule

`default_nettype wire

// ----- rtl/spq_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on spq_pkg.
`default_nettype none

module spq_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spq_pkg::flags_t flags_i,
  output spq_pkg::ctrl_t      ctrl_o,
  output logic                busy_o
);
  import spq_pkg::*;

  step_t step_q, step_d;
  ctrl_t cw;
  logic  cond_hit;

  assign cw = ucode_rom(step_q);

  always_comb begin
    case (cw.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NO_START:  cond_hit = !flags_i.start;
      COND_IS_LOAD:   cond_hit = flags_i.is_load;
      COND_RANGE_BAD: cond_hit = flags_i.range_bad;
      COND_PTR_MET:   cond_hit = flags_i.ptr_met;
      COND_PAIR_STOP: cond_hit = flags_i.pair_stop;
      default:        cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      step_d = cw.target;
    end else if (cw.els == ELSE_STAY) begin
      step_d = step_q;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = cw;
  assign busy_o = (step_q != STEP_IDLE);

endmodule

`default_nettype wire

// ----- rtl/spq_dpath.sv -----
// Datapath: item registers, element store with two read ports, pointer pair,
// range check, match flag and result register. Depends on spq_pkg.
`default_nettype none

module spq_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire spq_pkg::ctrl_t                ctrl_i,
  input  wire logic                          start_i,
  input  wire logic                          opcode_i,
  input  wire logic [spq_pkg::IDX_W-1:0]     first_index_i,
  input  wire logic [spq_pkg::IDX_W-1:0]     last_index_i,
  input  wire logic [spq_pkg::VALUE_W-1:0]   value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [spq_pkg::LEN_W-1:0]     cfg_wdata_i,
  output spq_pkg::flags_t                    flags_o,
  output logic                               result_valid_o,
  output logic                               is_palindrome_o,
  output logic                               range_error_o
);
  import spq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [MAX_ELEMENTS];

  logic                  op_q;
  logic [IDX_W-1:0]      lo_q, hi_q;
  logic [VALUE_W-1:0]    value_q;
  logic [LEN_W-1:0]      seq_len_q;
  logic [LEN_W-1:0]      len_eff;
  logic [DATA_WIDTH-1:0] rd_lo_q, rd_hi_q;
  logic                  match_q;
  logic                  valid_q, pal_q, err_q;
  logic [IDX_W-1:0]      ra_lo, ra_hi;
  logic [IDX_W-1:0]      span;
  logic                  take;
  logic                  wr_en;

  assign take  = ctrl_i.take_item && start_i;
  assign wr_en = ctrl_i.wr_load && !op_q && ({1'b0, lo_q} < MAX_LEN);

  // Address the next pair while the current one is being compared
  assign ra_lo = ctrl_i.ptr_adv ? lo_q + IDX_W'(1) : lo_q;
  assign ra_hi = ctrl_i.ptr_adv ? hi_q - IDX_W'(1) : hi_q;

  assign len_eff = (seq_len_q > MAX_LEN) ? MAX_LEN : seq_len_q;
  assign span    = hi_q - lo_q;

  assign flags_o.start     = start_i;
  assign flags_o.is_load   = !op_q;
  assign flags_o.range_bad = (lo_q > hi_q) || ({1'b0, hi_q} >= len_eff);
  assign flags_o.ptr_met   = (lo_q >= hi_q);
  assign flags_o.pair_stop = (rd_lo_q != rd_hi_q) || (span <= IDX_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SEQ_LEN_RESET;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seq_len_q <= cfg_wdata_i;
      end
      valid_q <= (ctrl_i.res != RES_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q    <= opcode_i;
      lo_q    <= first_index_i;
      hi_q    <= last_index_i;
      value_q <= value_i;
    end else if (ctrl_i.ptr_adv) begin
      lo_q <= ra_lo;
      hi_q <= ra_hi;
    end
    if (ctrl_i.set_match) begin
      match_q <= 1'b1;
    end else if (ctrl_i.latch_match) begin
      match_q <= (rd_lo_q == rd_hi_q);
    end
    case (ctrl_i.res)
      RES_MATCH: begin
        pal_q <= match_q;
        err_q <= 1'b0;
      end
      RES_ERR: begin
        pal_q <= 1'b0;
        err_q <= 1'b1;
      end
      default: begin
        pal_q <= pal_q;
        err_q <= err_q;
      end
    endcase
  end

  // Element store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[lo_q[ADDR_W-1:0]] <= value_q[DATA_WIDTH-1:0];
    end
    if (ctrl_i.rd_issue) begin
      rd_lo_q <= mem[ra_lo[ADDR_W-1:0]];
      rd_hi_q <= mem[ra_hi[ADDR_W-1:0]];
    end
  end

  assign result_valid_o  = valid_q;
  assign is_palindrome_o = pal_q;
  assign range_error_o   = err_q;

endmodule

`default_nettype wire

// ----- rtl/spq_checker.sv -----
// Port-level checker for the palindrome range query unit, bound to the top.
// Depends on spq_pkg and subarray_palindrome_query_unit_defines.svh.
`default_nettype none

`include "subarray_palindrome_query_unit_defines.svh"

module spq_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        busy_o,
  input  wire logic                        opcode_i,
  input  wire logic [spq_pkg::IDX_W-1:0]   first_index_i,
  input  wire logic [spq_pkg::IDX_W-1:0]   last_index_i,
  input  wire logic [spq_pkg::VALUE_W-1:0] value_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [spq_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  wire logic                        result_valid_o,
  input  wire logic                        is_palindrome_o,
  input  wire logic                        range_error_o
);
  import spq_pkg::*;

  logic accept;
  logic unused_inputs;

  assign accept        = start_i && !busy_o;
  assign unused_inputs = opcode_i ^ (^first_index_i) ^ (^last_index_i) ^ (^value_i)
                         ^ cfg_we_i ^ (^cfg_wdata_i);

  // An accepted item always makes the unit busy in the following cycle
  `SPQ_ASSERT(a_accept_busy, accept |=> busy_o)

  // A result strobe is never longer than one cycle
  `SPQ_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o)

  // Results are only shown once the unit is back to idle
  `SPQ_ASSERT(a_result_idle, result_valid_o |-> !busy_o)

  // A bad range never also claims a palindrome
  `SPQ_ASSERT(a_err_excl, (result_valid_o && range_error_o) |-> !is_palindrome_o)

  // A result follows directly on the fall of busy for a query
  `SPQ_ASSERT(a_result_after_busy, result_valid_o |-> $past(busy_o))

endmodule

bind subarray_palindrome_query_unit spq_checker u_spq_checker (.*);

`default_nettype wire
